>>> sv/svr_pkg.sv
`default_nettype none
package svr_pkg;
	localparam int FRAME_DEPTH_D = 65536;
	localparam int SAMPLE_BITS_D = 16;
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_REL = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;
	localparam logic [2:0] REG_LS = 3'd0;
	localparam logic [2:0] REG_LE = 3'd1;
	localparam logic [2:0] REG_LM = 3'd2;
	localparam logic [2:0] REG_LO = 3'd3;
	localparam logic [2:0] REG_SF = 3'd4;
	localparam logic [2:0] REG_AS = 3'd5;
	localparam logic [2:0] REG_RS = 3'd6;
	localparam logic [2:0] REG_MG = 3'd7;
	localparam logic [24:0] ONE_Q24 = 25'h1000000;
	localparam logic [15:0] ONE_Q15 = 16'h8000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] frame_index;
		logic [15:0] load_left;
		logic [15:0] load_right;
		logic [24:0] pitch_step;
		logic [15:0] velocity_gain;
		logic [23:0] mix_left_in;
		logic [23:0] mix_right_in;
	} item_t;
endpackage
`default_nettype wire

>>> sv/svr_front.sv
`default_nettype none
module svr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire svr_pkg::item_t    in_item,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output svr_pkg::item_t         q_item
);
	svr_pkg::item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !(q_valid && q_ready) |=> cnt_q == 2'd2)
		else $error("full queue lost an item");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 && !(in_valid && in_ready) |=> !q_valid)
		else $error("empty queue produced an item");
`endif
endmodule
`default_nettype wire

>>> sv/svr_back.sv
`default_nettype none
module svr_back #(
	parameter int FRAME_DEPTH = svr_pkg::FRAME_DEPTH_D,
	parameter int SAMPLE_BITS = svr_pkg::SAMPLE_BITS_D
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [24:0]       cfg_data,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  wire svr_pkg::item_t    q_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [23:0]            mix_left_out,
	output logic [23:0]            mix_right_out,
	output logic                   voice_active,
	output logic [15:0]            playhead_frame
);
	localparam int AW = $clog2(FRAME_DEPTH);
	localparam int SB = SAMPLE_BITS;
	localparam logic [4:0] S_IDLE = 5'd0, S_PREP = 5'd1, S_WRAP = 5'd2, S_DIVS = 5'd3,
		S_DIV = 5'd4, S_DIVE = 5'd5, S_CHK = 5'd6, S_RD0 = 5'd7, S_RD1 = 5'd8,
		S_RD2 = 5'd9, S_INT = 5'd10, S_INT2 = 5'd11, S_ENV = 5'd12, S_ENV1 = 5'd13,
		S_ENV2 = 5'd14, S_ENV3 = 5'd15, S_MIX = 5'd16, S_MIX2 = 5'd17, S_OUT = 5'd18,
		S_PP2 = 5'd19;

	logic [15:0] ls_r_q, le_r_q, mg_r_q;
	logic [1:0]  lm_q;
	logic        lo_q;
	logic [16:0] sf_q;
	logic [24:0] as_r_q, rs_r_q;

	logic signed [SB-1:0] lmem [FRAME_DEPTH];
	logic signed [SB-1:0] rmem [FRAME_DEPTH];

	logic signed [35:0] pos_q;
	logic fwd_q, rel_q, snd_q;
	logic [24:0] fade_q, att_q, step_q;
	logic [15:0] ng_q;

	logic [4:0] st_q;
	svr_pkg::item_t it_q;
	logic [23:0] ol_q, or_q;
	logic ov_q;

	// Derived configuration.
	logic [16:0] frames;
	logic [15:0] last, ls, le;
	logic [1:0]  kind;
	logic        lp;
	always_comb begin
		frames = sf_q;
		if (frames == 17'd0) frames = 17'd1;
		if ({15'd0, frames} > 32'(FRAME_DEPTH)) frames = 17'(FRAME_DEPTH);
		last = 16'(frames - 17'd1);
		ls = (ls_r_q < last) ? ls_r_q : last;
		le = (le_r_q < last) ? le_r_q : last;
		kind = (lm_q == 2'd3) ? 2'd0 : lm_q;
		if (kind == 2'd0 && lo_q) kind = 2'd1;
		lp = kind != 2'd0 && le > ls;
	end
	logic signed [35:0] lsu, leu, len;
	assign lsu = $signed({4'd0, ls, 16'd0});
	assign leu = $signed({4'd0, le, 16'd0});
	assign len = leu - lsu;

	// Divider for the floor modulo: remainder of num by den, num nonnegative.
	logic [35:0] dnum_q, drem_q, dden_q;
	logic [5:0]  dcnt_q;
	logic [36:0] dtry;
	assign dtry = {drem_q, dnum_q[35]} - {1'b0, dden_q};

	logic signed [35:0] p_q, t_q;
	logic neg_q, ppm_q;
	logic [AW-1:0] a0_q, a1_q;
	logic signed [SB-1:0] l0_q, l1_q, r0_q, r1_q;
	logic signed [SB+1:0] sl_q, sr_q;
	logic signed [SB+17:0] pl_q, pr_q;
	logic [40:0] gm_q;
	logic [49:0] fa_q;
	logic [40:0] env_q;
	logic [24:0] env25_q;
	logic signed [SB+27:0] vl_q, vr_q;

	logic signed [35:0] stp;
	assign stp = $signed({11'd0, step_q});
	logic [24:0] ast, rst;
	assign ast = (as_r_q < svr_pkg::ONE_Q24) ? as_r_q : svr_pkg::ONE_Q24;
	assign rst = (rs_r_q == 25'd0) ? 25'd1 : ((rs_r_q < svr_pkg::ONE_Q24) ? rs_r_q : svr_pkg::ONE_Q24);

	logic signed [35:0] ph_s;
	logic [15:0] ph_sat;
	always_comb begin
		ph_s = pos_q >>> 16;
		if (ph_s < 0) ph_sat = 16'd0;
		else if (ph_s > 36'sd65535) ph_sat = 16'hFFFF;
		else ph_sat = ph_s[15:0];
	end

	function automatic logic [23:0] sat24(input logic signed [25:0] x);
		if (x > 26'sd8388607) return 24'h7FFFFF;
		if (x < -26'sd8388608) return 24'h800000;
		return x[23:0];
	endfunction

	assign q_ready = st_q == S_IDLE && !ov_q;
	assign out_valid = ov_q;
	assign mix_left_out = ol_q;
	assign mix_right_out = or_q;
	assign voice_active = snd_q;
	assign playhead_frame = ph_sat;

	always_ff @(posedge clk) begin
		if (q_valid && q_ready && q_item.cmd == svr_pkg::CMD_LOAD &&
		    {16'd0, q_item.frame_index} < 32'(FRAME_DEPTH)) begin
			lmem[AW'(q_item.frame_index)] <= SB'(q_item.load_left);
			rmem[AW'(q_item.frame_index)] <= SB'(q_item.load_right);
		end
		if (st_q == S_RD0) begin
			l0_q <= lmem[a0_q];
			r0_q <= rmem[a0_q];
		end
		if (st_q == S_RD1) begin
			l1_q <= lmem[a1_q];
			r1_q <= rmem[a1_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_r_q <= 16'd0; le_r_q <= 16'd0; lm_q <= 2'd0; lo_q <= 1'b0;
			sf_q <= 17'd1; as_r_q <= 25'd0; rs_r_q <= svr_pkg::ONE_Q24;
			mg_r_q <= svr_pkg::ONE_Q15;
			pos_q <= '0; fwd_q <= 1'b1; fade_q <= svr_pkg::ONE_Q24;
			att_q <= svr_pkg::ONE_Q24; ng_q <= 16'd0; step_q <= 25'h10000;
			rel_q <= 1'b0; snd_q <= 1'b0;
			st_q <= S_IDLE; ov_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					svr_pkg::REG_LS: ls_r_q <= cfg_data[15:0];
					svr_pkg::REG_LE: le_r_q <= cfg_data[15:0];
					svr_pkg::REG_LM: lm_q <= cfg_data[1:0];
					svr_pkg::REG_LO: lo_q <= cfg_data[0];
					svr_pkg::REG_SF: sf_q <= cfg_data[16:0];
					svr_pkg::REG_AS: as_r_q <= cfg_data;
					svr_pkg::REG_RS: rs_r_q <= cfg_data;
					svr_pkg::REG_MG: mg_r_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (st_q)
				S_IDLE: if (q_valid && q_ready) begin
					it_q <= q_item;
					ol_q <= q_item.mix_left_in;
					or_q <= q_item.mix_right_in;
					case (q_item.cmd)
						svr_pkg::CMD_START: begin
							if (q_item.pitch_step < 25'd256) step_q <= 25'd256;
							else if (q_item.pitch_step > svr_pkg::ONE_Q24) step_q <= svr_pkg::ONE_Q24;
							else step_q <= q_item.pitch_step;
							ng_q <= (q_item.velocity_gain < svr_pkg::ONE_Q15) ?
								q_item.velocity_gain : svr_pkg::ONE_Q15;
							fwd_q <= 1'b1;
							pos_q <= lo_q ? lsu : '0;
							att_q <= (as_r_q != 25'd0) ? 25'd0 : svr_pkg::ONE_Q24;
							fade_q <= svr_pkg::ONE_Q24;
							rel_q <= 1'b0;
							snd_q <= 1'b1;
							ov_q <= 1'b1;
						end
						svr_pkg::CMD_REL: begin
							if (snd_q) rel_q <= 1'b1;
							ov_q <= 1'b1;
						end
						svr_pkg::CMD_TICK: begin
							if (snd_q) begin
								p_q <= pos_q;
								st_q <= S_PREP;
							end else ov_q <= 1'b1;
						end
						default: ov_q <= 1'b1;
					endcase
				end
				S_PREP: begin
					if (lp) begin
						if (kind == 2'd1) begin
							if (p_q > leu) begin
								t_q <= p_q - lsu;
								dden_q <= 36'(len + 36'sd65536);
								ppm_q <= 1'b0;
								st_q <= S_DIVS;
							end else st_q <= S_CHK;
						end else if ((fwd_q && p_q > leu) || (!fwd_q && p_q < lsu)) begin
							st_q <= S_WRAP;
						end else st_q <= S_CHK;
					end else if (p_q >= $signed({4'd0, last, 16'd0})) begin
						pos_q <= p_q;
						snd_q <= 1'b0;
						ov_q <= 1'b1;
						st_q <= S_IDLE;
					end else st_q <= S_CHK;
				end
				S_WRAP: begin
					if (fwd_q) begin p_q <= (leu <<< 1) - p_q; fwd_q <= 1'b0; end
					else begin p_q <= (lsu <<< 1) - p_q; fwd_q <= 1'b1; end
					st_q <= S_PP2;
				end
				S_PP2: begin
					if (p_q < lsu || p_q > leu) begin
						t_q <= p_q - lsu;
						dden_q <= 36'(len <<< 1);
						ppm_q <= 1'b1;
						st_q <= S_DIVS;
					end else st_q <= S_CHK;
				end
				S_DIVS: begin
					neg_q <= t_q < 0;
					dnum_q <= (t_q < 0) ? 36'(-t_q) : 36'(t_q);
					drem_q <= '0;
					dcnt_q <= 6'd36;
					st_q <= S_DIV;
				end
				S_DIV: begin
					if (!dtry[36]) drem_q <= dtry[35:0];
					else drem_q <= {drem_q[34:0], dnum_q[35]};
					dnum_q <= dnum_q << 1;
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) st_q <= S_DIVE;
				end
				S_DIVE: begin
					logic signed [35:0] r;
					r = $signed(drem_q);
					if (neg_q && r != 0) r = $signed(dden_q) - r;
					if (!ppm_q) p_q <= lsu + r;
					else if (r > len) begin p_q <= lsu + (len <<< 1) - r; fwd_q <= 1'b0; end
					else begin p_q <= lsu + r; fwd_q <= 1'b1; end
					st_q <= S_CHK;
				end
				S_CHK: begin
					pos_q <= p_q;
					if (p_q < 0 || p_q >= $signed({3'd0, frames, 16'd0})) begin
						snd_q <= 1'b0;
						ov_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						a0_q <= AW'(p_q[35:16]);
						if (lp && kind == 2'd1 && {1'b0, p_q[31:16]} + 17'd1 > {1'b0, le})
							a1_q <= AW'(ls);
						else if ({1'b0, p_q[31:16]} + 17'd1 >= frames) a1_q <= AW'(p_q[35:16]);
						else a1_q <= AW'(p_q[31:16] + 16'd1);
						st_q <= S_RD0;
					end
				end
				S_RD0: st_q <= S_RD1;
				S_RD1: st_q <= S_RD2;
				S_RD2: begin
					sl_q <= (SB+2)'(l1_q) - (SB+2)'(l0_q);
					sr_q <= (SB+2)'(r1_q) - (SB+2)'(r0_q);
					st_q <= S_INT;
				end
				S_INT: begin
					pl_q <= $signed({2'b0, p_q[15:0]}) * sl_q;
					pr_q <= $signed({2'b0, p_q[15:0]}) * sr_q;
					st_q <= S_INT2;
				end
				S_INT2: begin
					sl_q <= (SB+2)'(l0_q) + (SB+2)'(pl_q >>> 16);
					sr_q <= (SB+2)'(r0_q) + (SB+2)'(pr_q >>> 16);
					if (att_q < svr_pkg::ONE_Q24) begin
						if ({1'b0, att_q} + {1'b0, ast} > {1'b0, svr_pkg::ONE_Q24})
							att_q <= svr_pkg::ONE_Q24;
						else att_q <= att_q + ast;
					end
					st_q <= S_ENV;
				end
				S_ENV: begin
					if (rel_q) begin
						if (fade_q <= rst) begin
							fade_q <= '0;
							snd_q <= 1'b0;
							ov_q <= 1'b1;
							st_q <= S_IDLE;
						end else begin
							fade_q <= fade_q - rst;
							st_q <= S_ENV1;
						end
					end else st_q <= S_ENV1;
				end
				S_ENV1: begin
					gm_q <= {25'd0, ((mg_r_q < svr_pkg::ONE_Q15) ? mg_r_q : svr_pkg::ONE_Q15)} *
						{25'd0, ng_q};
					fa_q <= {25'd0, fade_q} * {25'd0, att_q};
					st_q <= S_ENV2;
				end
				S_ENV2: begin
					env_q <= {15'd0, fa_q[49:24]} * {24'd0, gm_q[31:15]};
					st_q <= S_ENV3;
				end
				S_ENV3: begin
					env25_q <= env_q[39:15];
					st_q <= S_MIX;
				end
				S_MIX: begin
					vl_q <= sl_q * $signed({1'b0, env25_q}) + (SB+28)'(1 <<< SB);
					vr_q <= sr_q * $signed({1'b0, env25_q}) + (SB+28)'(1 <<< SB);
					st_q <= S_MIX2;
				end
				S_MIX2: begin
					ol_q <= sat24($signed({{2{it_q.mix_left_in[23]}}, it_q.mix_left_in}) +
						26'(vl_q >>> (SB+1)));
					or_q <= sat24($signed({{2{it_q.mix_right_in[23]}}, it_q.mix_right_in}) +
						26'(vr_q >>> (SB+1)));
					pos_q <= fwd_q ? p_q + stp : p_q - stp;
					st_q <= S_OUT;
				end
				S_OUT: begin
					ov_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != S_IDLE |-> !q_ready)
		else $error("accepted an item while busy");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> ov_q)
		else $error("result dropped");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> dcnt_q != 6'd0)
		else $error("divider overran");
`endif
endmodule
`default_nettype wire

>>> sv/sample_voice_renderer.sv
`default_nettype none
// Channel  Handshake              Payload
// in       in_valid / in_ready    cmd .. mix_right_in
// out      out_valid / out_ready  mix_left_out .. playhead_frame
// cfg      cfg_we                 cfg_index, cfg_data
// Load, start and release finish in the idle state; a tick walks the render states,
// plus the ping-pong reflection states and, for a loop fold, the 36-step remainder unit.
// A two-entry queue takes items while the back end works.
// Reset clears the registers; the frame store is not cleared.
module sample_voice_renderer #(
	parameter int FRAME_DEPTH = svr_pkg::FRAME_DEPTH_D,
	parameter int SAMPLE_BITS = svr_pkg::SAMPLE_BITS_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [24:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] frame_index,
	input  wire logic [15:0] load_left,
	input  wire logic [15:0] load_right,
	input  wire logic [24:0] pitch_step,
	input  wire logic [15:0] velocity_gain,
	input  wire logic [23:0] mix_left_in,
	input  wire logic [23:0] mix_right_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [23:0]      mix_left_out,
	output logic [23:0]      mix_right_out,
	output logic             voice_active,
	output logic [15:0]      playhead_frame
);
	svr_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;
	assign in_item = '{cmd: cmd, frame_index: frame_index, load_left: load_left,
		load_right: load_right, pitch_step: pitch_step, velocity_gain: velocity_gain,
		mix_left_in: mix_left_in, mix_right_in: mix_right_in};

	svr_front u_front (.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

	svr_back #(.FRAME_DEPTH(FRAME_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .mix_left_out(mix_left_out),
		.mix_right_out(mix_right_out), .voice_active(voice_active),
		.playhead_frame(playhead_frame));
endmodule
`default_nettype wire

>>> sim/mix_checker.sv
`timescale 1ns / 100ps
module mix_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [24:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] frame_index,
	input  wire logic [15:0] load_left,
	input  wire logic [15:0] load_right,
	input  wire logic [24:0] pitch_step,
	input  wire logic [15:0] velocity_gain,
	input  wire logic [23:0] mix_left_in,
	input  wire logic [23:0] mix_right_in,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [23:0] mix_left_out,
	input  wire logic [23:0] mix_right_out,
	input  wire logic        voice_active,
	input  wire logic [15:0] playhead_frame,
	output int               errors,
	output int               pending,
	output int               ticks_sounded
);
	localparam logic [1:0] LOOP_NONE = 2'd0;
	localparam logic [1:0] LOOP_FWD = 2'd1;
	localparam longint UNIT = 65536;
	localparam longint Q24 = 16777216;
	localparam longint Q15 = 32768;

	typedef struct {
		logic [23:0] left;
		logic [23:0] right;
		logic        active;
		logic [15:0] frame;
	} mix_result_t;

	mix_result_t expected_mix[$];

	logic signed [15:0] left_store [svr_pkg::FRAME_DEPTH_D];
	logic signed [15:0] right_store [svr_pkg::FRAME_DEPTH_D];
	longint play_pos, fade, attack, gain, step;
	bit forward, fading, sounding;
	longint r_ls, r_le, r_mode, r_only, r_frames, r_attack, r_release, r_master;

	function automatic longint fmod(longint a, longint m);
		longint r;
		r = a % m;
		if (r < 0) r += m;
		return r;
	endfunction

	function automatic longint lmin(longint a, longint b);
		return a < b ? a : b;
	endfunction

	function automatic longint sat24(longint x);
		if (x > 8388607) return 8388607;
		if (x < -8388608) return -8388608;
		return x;
	endfunction

	function automatic longint frame_count();
		longint f;
		f = r_frames;
		if (f == 0) f = 1;
		if (f > svr_pkg::FRAME_DEPTH_D) f = svr_pkg::FRAME_DEPTH_D;
		return f;
	endfunction

	function automatic bit advance_voice(output longint add_l, output longint add_r);
		longint frames, last, ls, le, lsu, leu, len, p, ast, rst, t;
		longint i0, i1, frac, l0, l1, r0, r1, sl, sr, g, fa, env;
		logic [1:0] kind;
		bit looped;
		add_l = 0;
		add_r = 0;
		frames = frame_count();
		last = frames - 1;
		ls = lmin(r_ls, last);
		le = lmin(r_le, last);
		kind = (r_mode == 3) ? LOOP_NONE : r_mode[1:0];
		if (kind == LOOP_NONE && r_only != 0) kind = LOOP_FWD;
		looped = kind != LOOP_NONE && le > ls;
		lsu = ls * UNIT;
		leu = le * UNIT;
		len = (le - ls) * UNIT;
		p = play_pos;
		ast = lmin(r_attack, Q24);
		rst = (r_release == 0) ? 1 : lmin(r_release, Q24);
		if (looped) begin
			if (kind == LOOP_FWD) begin
				if (p > leu) p = lsu + fmod(p - lsu, len + UNIT);
			end else if ((forward && p > leu) || (!forward && p < lsu)) begin
				if (forward) begin
					p = 2 * leu - p;
					forward = 0;
				end else begin
					p = 2 * lsu - p;
					forward = 1;
				end
				if (p < lsu || p > leu) begin
					t = fmod(p - lsu, 2 * len);
					if (t > len) begin
						p = lsu + 2 * len - t;
						forward = 0;
					end else begin
						p = lsu + t;
						forward = 1;
					end
				end
			end
		end else if (p >= last * UNIT) begin
			play_pos = p;
			sounding = 0;
			return 0;
		end
		play_pos = p;
		if (p < 0 || p >= frames * UNIT) begin
			sounding = 0;
			return 0;
		end
		i0 = p / UNIT;
		frac = p % UNIT;
		i1 = i0 + 1;
		if (looped && kind == LOOP_FWD && i1 > le) i1 = ls;
		else if (i1 >= frames) i1 = i0;
		l0 = left_store[i0];
		l1 = left_store[i1];
		r0 = right_store[i0];
		r1 = right_store[i1];
		sl = l0 + ((frac * (l1 - l0)) >>> 16);
		sr = r0 + ((frac * (r1 - r0)) >>> 16);
		if (attack < Q24) begin
			attack += ast;
			if (attack > Q24) attack = Q24;
		end
		if (fading) begin
			fade -= rst;
			if (fade <= 0) begin
				fade = 0;
				sounding = 0;
				return 0;
			end
		end
		g = (lmin(r_master, Q15) * gain) >>> 15;
		fa = (fade * attack) >>> 24;
		env = (fa * g) >>> 15;
		add_l = (sl * env + 65536) >>> 17;
		add_r = (sr * env + 65536) >>> 17;
		play_pos = p + (forward ? step : -step);
		return 1;
	endfunction

	function automatic mix_result_t render_item();
		mix_result_t res;
		longint ml, mr, al, ar, st, ph;
		ml = longint'($signed(mix_left_in));
		mr = longint'($signed(mix_right_in));
		case (cmd)
			svr_pkg::CMD_LOAD: begin
				left_store[frame_index] = load_left;
				right_store[frame_index] = load_right;
			end
			svr_pkg::CMD_START: begin
				st = pitch_step;
				if (st < 256) st = 256;
				if (st > Q24) st = Q24;
				step = st;
				gain = lmin(velocity_gain, Q15);
				forward = 1;
				play_pos = (r_only != 0) ? lmin(r_ls, frame_count() - 1) * UNIT : 0;
				attack = (r_attack > 0) ? 0 : Q24;
				fade = Q24;
				fading = 0;
				sounding = 1;
			end
			svr_pkg::CMD_REL: begin
				if (sounding && !fading) fading = 1;
			end
			default: begin
				if (sounding) begin
					if (advance_voice(al, ar)) begin
						ml = sat24(ml + al);
						mr = sat24(mr + ar);
						ticks_sounded++;
					end
				end
			end
		endcase
		ph = play_pos >>> 16;
		if (ph < 0) ph = 0;
		if (ph > 65535) ph = 65535;
		res.left = ml[23:0];
		res.right = mr[23:0];
		res.active = sounding;
		res.frame = ph[15:0];
		return res;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("%0t: %s got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		ticks_sounded = 0;
	end

	assign pending = expected_mix.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_mix.delete();
			play_pos = 0;
			forward = 1;
			fade = Q24;
			attack = Q24;
			gain = 0;
			step = UNIT;
			fading = 0;
			sounding = 0;
			r_ls = 0;
			r_le = 0;
			r_mode = 0;
			r_only = 0;
			r_frames = 1;
			r_attack = 0;
			r_release = Q24;
			r_master = Q15;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					svr_pkg::REG_LS: r_ls = cfg_data[15:0];
					svr_pkg::REG_LE: r_le = cfg_data[15:0];
					svr_pkg::REG_LM: r_mode = cfg_data[1:0];
					svr_pkg::REG_LO: r_only = cfg_data[0];
					svr_pkg::REG_SF: r_frames = cfg_data[16:0];
					svr_pkg::REG_AS: r_attack = cfg_data;
					svr_pkg::REG_RS: r_release = cfg_data;
					svr_pkg::REG_MG: r_master = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_mix.size() == 0) begin
					report("unexpected result", mix_left_out, 0);
				end else begin
					mix_result_t want;
					want = expected_mix.pop_front();
					if (mix_left_out !== want.left) report("mix_left_out", mix_left_out, want.left);
					if (mix_right_out !== want.right)
						report("mix_right_out", mix_right_out, want.right);
					if (voice_active !== want.active)
						report("voice_active", voice_active, want.active);
					if (playhead_frame !== want.frame)
						report("playhead_frame", playhead_frame, want.frame);
				end
			end
			if (in_valid && in_ready) expected_mix.push_back(render_item());
		end
	end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
	localparam int LIMIT = 1000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = svr_pkg::REG_LS;
	logic [24:0] cfg_data = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  cmd = svr_pkg::CMD_LOAD;
	logic [15:0] frame_index = 0;
	logic [15:0] load_left = 0;
	logic [15:0] load_right = 0;
	logic [24:0] pitch_step = 0;
	logic [15:0] velocity_gain = 0;
	logic [23:0] mix_left_in = 0;
	logic [23:0] mix_right_in = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [23:0] mix_left_out;
	logic [23:0] mix_right_out;
	logic        voice_active;
	logic [15:0] playhead_frame;

	int errors, pending, ticks_sounded;
	int sent = 0;
	int phases = 0;
	int cycles = 0;
	int hold_left = 0;
	bit held = 0;
	bit no_idle = 0;

	always #1 clk = ~clk;

	sample_voice_renderer DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.frame_index(frame_index), .load_left(load_left), .load_right(load_right),
		.pitch_step(pitch_step), .velocity_gain(velocity_gain),
		.mix_left_in(mix_left_in), .mix_right_in(mix_right_in), .out_valid(out_valid),
		.out_ready(out_ready), .mix_left_out(mix_left_out), .mix_right_out(mix_right_out),
		.voice_active(voice_active), .playhead_frame(playhead_frame)
	);

	mix_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.frame_index(frame_index), .load_left(load_left), .load_right(load_right),
		.pitch_step(pitch_step), .velocity_gain(velocity_gain),
		.mix_left_in(mix_left_in), .mix_right_in(mix_right_in), .out_valid(out_valid),
		.out_ready(out_ready), .mix_left_out(mix_left_out), .mix_right_out(mix_right_out),
		.voice_active(voice_active), .playhead_frame(playhead_frame),
		.errors(errors), .pending(pending), .ticks_sounded(ticks_sounded)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("sample_voice_renderer: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 0;
			hold_left <= hold_left - 1;
		end else if (sent >= 600 && !held) begin
			held <= 1;
			hold_left <= 400;
			out_ready <= 0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 8);
		end
	end

	function automatic logic [23:0] pick_mix();
		case ($urandom_range(9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic svr_pkg::item_t make_item(logic [1:0] c);
		svr_pkg::item_t it;
		it.cmd = c;
		it.frame_index = 16'($urandom());
		it.load_left = 16'($urandom());
		it.load_right = 16'($urandom());
		case ($urandom_range(9))
			0: it.pitch_step = 25'($urandom());
			1: it.pitch_step = $urandom_range(1) ? 25'h1FFFFFF : 25'd0;
			2: it.pitch_step = 25'($urandom_range(256, 25'h1000000));
			default: it.pitch_step = 25'($urandom_range(256, 25'h30000));
		endcase
		it.velocity_gain = ($urandom_range(9) == 0) ? 16'hFFFF :
			16'($urandom_range(0, 32768));
		it.mix_left_in = pick_mix();
		it.mix_right_in = pick_mix();
		return it;
	endfunction

	function automatic svr_pkg::item_t random_item();
		int r;
		r = $urandom_range(99);
		if (r < 62) return make_item(svr_pkg::CMD_TICK);
		if (r < 73) return make_item(svr_pkg::CMD_START);
		if (r < 81) return make_item(svr_pkg::CMD_REL);
		return make_item(svr_pkg::CMD_LOAD);
	endfunction

	task automatic send(svr_pkg::item_t it);
		if (!no_idle && $urandom_range(99) < 8) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= it.cmd;
		frame_index <= it.frame_index;
		load_left <= it.load_left;
		load_right <= it.load_right;
		pitch_step <= it.pitch_step;
		velocity_gain <= it.velocity_gain;
		mix_left_in <= it.mix_left_in;
		mix_right_in <= it.mix_right_in;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic load_frame(int idx);
		svr_pkg::item_t it;
		it = make_item(svr_pkg::CMD_LOAD);
		it.frame_index = 16'(idx);
		send(it);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [24:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic run_phase(int ls, int le, int mode, int only, int frames, int atk, int rel,
		int mg, int lo, int hi, int count);
		drain();
		write_reg(svr_pkg::REG_LS, 25'(ls));
		write_reg(svr_pkg::REG_LE, 25'(le));
		write_reg(svr_pkg::REG_LM, 25'(mode));
		write_reg(svr_pkg::REG_LO, 25'(only));
		write_reg(svr_pkg::REG_SF, 25'(frames));
		write_reg(svr_pkg::REG_AS, 25'(atk));
		write_reg(svr_pkg::REG_RS, 25'(rel));
		write_reg(svr_pkg::REG_MG, 25'(mg));
		cfg_we <= 0;
		@(posedge clk);
		for (int i = lo; i <= hi; i++) load_frame(i);
		send(make_item(svr_pkg::CMD_START));
		repeat (count) send(random_item());
		phases++;
	endtask

	task automatic directed();
		svr_pkg::item_t it;
		it = make_item(svr_pkg::CMD_REL);
		send(it);
		it = make_item(svr_pkg::CMD_TICK);
		it.mix_left_in = 24'h7FFFFF;
		it.mix_right_in = 24'h800000;
		send(it);
		it = make_item(svr_pkg::CMD_LOAD);
		it.frame_index = 16'hFFFF;
		it.load_left = 16'h7FFF;
		it.load_right = 16'h8000;
		send(it);
		it.frame_index = 0;
		send(it);
		it.frame_index = 1;
		it.load_left = 16'h8000;
		it.load_right = 16'h7FFF;
		send(it);
		it = make_item(svr_pkg::CMD_START);
		it.pitch_step = 0;
		it.velocity_gain = 16'hFFFF;
		send(it);
		for (int i = 0; i < 4; i++) begin
			it = make_item(svr_pkg::CMD_TICK);
			it.mix_left_in = i[0] ? 24'h800000 : 24'h7FFFFF;
			it.mix_right_in = i[0] ? 24'h7FFFFF : 24'h800000;
			send(it);
		end
		it = make_item(svr_pkg::CMD_START);
		it.pitch_step = 25'h1FFFFFF;
		it.velocity_gain = 16'h8000;
		send(it);
		repeat (3) send(make_item(svr_pkg::CMD_TICK));
		send(make_item(svr_pkg::CMD_REL));
		send(make_item(svr_pkg::CMD_REL));
		repeat (6) send(make_item(svr_pkg::CMD_TICK));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		run_phase(2, 5, 1, 0, 8, 0, 25'h1000000, 32768, 0, 7, 0);
		directed();
		run_phase(1, 6, 2, 0, 12, 25'h1000000, 1, 32768, 0, 11, 90);
		run_phase(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 40);
		run_phase(3, 40, 1, 1, 20, 25'h1FFFFFF, 25'h1FFFFFF, 16'hFFFF, 0, 19, 90);
		no_idle = 1;
		run_phase(4, 9, 2, 1, 30, 1, 300000, 20000, 0, 29, 100);
		no_idle = 0;
		run_phase(10, 3, 3, 1, 16, 40000, 2000, 32768, 0, 15, 80);
		run_phase(5, 30, 0, 0, 24, 500000, 100000, 30000, 0, 23, 90);
		run_phase(16'hFFFF, 16'hFFFF, 2, 0, 40, 0, 50000, 32768, 0, 39, 90);
		run_phase(65000, 65010, 2, 1, 17'h1FFFF, 200000, 20000, 32768, 65000, 65011, 90);
		run_phase(65520, 65535, 1, 1, 65536, 0, 3, 25000, 65520, 65535, 90);
		run_phase(0, 31, 1, 0, 32, 80000, 400000, 32768, 0, 31, 100);
		run_phase(2, 7, 2, 0, 9, 0, 25'h1000000, 1, 0, 8, 60);
		drain();
		$display("%0d items sent over %0d phases, %0d audible ticks, %0d cycles",
			sent, phases, ticks_sounded, cycles);
		$display("covered loop modes, loop-only starts, clamped registers and a long output hold");
		if (errors == 0) begin
			$display("sample_voice_renderer: match");
		end else begin
			$display("sample_voice_renderer: mismatch");
		end
		$finish;
	end
endmodule
